// ----- src/cbq_pkg.sv -----
// Shared types, formats, coefficient tables and rounding function of the
// cascaded biquad filter. No dependencies.

package cbq_pkg;

	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int DEF_NUM_SECTIONS = 3;

	localparam int IW         = 24;
	localparam int CW         = 16;
	localparam int PROD_W     = IW + CW;
	localparam int ACC_W      = PROD_W + 2;
	localparam int FRAC_COEF  = 14;
	localparam int FRAC_INT   = 20;
	localparam int TABLE_ROWS = 8;
	localparam int ROW_W      = $clog2(TABLE_ROWS);
	localparam int STEP_W     = 3;
	localparam int INT_MAX24  = 8388607;
	localparam int INT_MIN24  = -8388608;

	typedef logic signed [CW-1:0]     coef_t;
	typedef logic signed [IW-1:0]     int_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	localparam logic [STEP_W-1:0] STEP_G  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_A1 = 3'd1;
	localparam logic [STEP_W-1:0] STEP_A2 = 3'd2;
	localparam logic [STEP_W-1:0] STEP_B1 = 3'd3;
	localparam logic [STEP_W-1:0] STEP_B2 = 3'd4;
	localparam logic [STEP_W-1:0] STEP_B0 = 3'd5;
	localparam logic [STEP_W-1:0] STEP_Y  = 3'd6;
	localparam logic [STEP_W-1:0] STEP_V  = 3'd7;

	localparam coef_t COEF_A1 [TABLE_ROWS] = '{-16'sd17547, 16'sd8897, -16'sd2916,
		16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
	localparam coef_t COEF_A2 [TABLE_ROWS] = '{16'sd13812, 16'sd13418, 16'sd229,
		16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
	localparam coef_t COEF_B0 [TABLE_ROWS] = '{16'sd16384, 16'sd16384, 16'sd16384,
		16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384};
	localparam coef_t COEF_B1 [TABLE_ROWS] = '{-16'sd11420, 16'sd295, -16'sd5751,
		16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
	localparam coef_t COEF_B2 [TABLE_ROWS] = '{16'sd16384, 16'sd16384, 16'sd16384,
		16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
	localparam coef_t COEF_G [TABLE_ROWS] = '{16'sd9880, 16'sd9880, 16'sd15860,
		16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384};

	typedef struct packed {
		logic              load;
		logic              active;
		logic [STEP_W-1:0] step;
		logic [ROW_W-1:0]  row;
		logic              clr;
	} dp_ctl_t;

	// Q8.34 sum to Q4.20, rounded half up and saturated to 24 bits.
	function automatic int_t to_internal(acc_t a);
		acc_t t;
		t = (a + acc_t'(1 <<< (FRAC_COEF - 1))) >>> FRAC_COEF;
		if (t > acc_t'(INT_MAX24)) begin
			return int_t'(INT_MAX24);
		end else if (t < acc_t'(INT_MIN24)) begin
			return int_t'(INT_MIN24);
		end
		return t[IW-1:0];
	endfunction

endpackage

// ----- src/cbq_ifs.sv -----
// Valid/ready channel interfaces for the filter's input and output words.
// Depends on nothing; widths are set per instance.

interface cbq_in_if #(parameter int SAMPLE_WIDTH = 16);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;
	logic                           restart;

	modport source (output valid, output sample_in, output restart, input ready);
	modport sink (input valid, input sample_in, input restart, output ready);
endinterface

interface cbq_out_if #(parameter int SAMPLE_WIDTH = 16);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

// ----- src/cbq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.

module cbq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 3,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/cbq_datapath.sv -----
// Shared multiply-accumulate datapath of the biquad sections, with format
// conversion at input and output. Depends on cbq_pkg.

module cbq_datapath import cbq_pkg::*; #(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  logic                           clk,
	input  dp_ctl_t                        ctl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic [2*IW-1:0]                rd_data,
	output logic [2*IW-1:0]                wr_data,
	output logic signed [SAMPLE_WIDTH-1:0] result
);

	localparam int SHL = (SAMPLE_WIDTH <= FRAC_INT + 1) ? FRAC_INT + 1 - SAMPLE_WIDTH : 0;
	localparam int SHR = (SAMPLE_WIDTH > FRAC_INT + 1) ? SAMPLE_WIDTH - FRAC_INT - 1 : 0;
	localparam longint RND = (longint'(1) <<< SHL) >>> 1;
	localparam longint SMAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
	localparam longint SMIN = -SMAX - 1;

	int_t  v_q;
	int_t  d1_q;
	int_t  d2_q;
	int_t  w_q;
	acc_t  acc_q;
	prod_t prod_q;

	int_t  rd_d1;
	int_t  rd_d2;
	coef_t mc;
	int_t  mo;
	prod_t prod_d;
	acc_t  prod_ext;
	int_t  v_in;
	longint x_ext;
	longint o_sh;

	assign rd_d1    = ctl.clr ? int_t'(0) : rd_data[2*IW-1:IW];
	assign rd_d2    = ctl.clr ? int_t'(0) : rd_data[IW-1:0];
	assign prod_ext = acc_t'(prod_q);
	assign wr_data  = {w_q, d1_q};

	always_comb begin
		case (ctl.step)
			STEP_G: begin
				mc = COEF_G[ctl.row];
				mo = v_q;
			end
			STEP_A1: begin
				mc = COEF_A1[ctl.row];
				mo = rd_d1;
			end
			STEP_A2: begin
				mc = COEF_A2[ctl.row];
				mo = d2_q;
			end
			STEP_B1: begin
				mc = COEF_B1[ctl.row];
				mo = d1_q;
			end
			STEP_B2: begin
				mc = COEF_B2[ctl.row];
				mo = d2_q;
			end
			STEP_B0: begin
				mc = COEF_B0[ctl.row];
				mo = w_q;
			end
			default: begin
				mc = coef_t'(0);
				mo = int_t'(0);
			end
		endcase
		prod_d = prod_t'(mc) * prod_t'(mo);
	end

	always_comb begin
		x_ext = longint'(sample);
		v_in  = int_t'((x_ext <<< SHL) >>> SHR);
		o_sh  = ((longint'(v_q) + RND) >>> SHL) <<< SHR;
		if (o_sh > SMAX) begin
			result = SAMPLE_WIDTH'(SMAX);
		end else if (o_sh < SMIN) begin
			result = SAMPLE_WIDTH'(SMIN);
		end else begin
			result = SAMPLE_WIDTH'(o_sh);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			v_q <= v_in;
		end else if (ctl.active) begin
			prod_q <= prod_d;
			case (ctl.step)
				STEP_A1: begin
					acc_q <= acc_t'(to_internal(prod_ext)) <<< FRAC_COEF;
					d1_q  <= rd_d1;
					d2_q  <= rd_d2;
				end
				STEP_A2, STEP_B1: begin
					acc_q <= acc_q - prod_ext;
				end
				STEP_B2: begin
					w_q   <= to_internal(acc_q);
					acc_q <= prod_ext;
				end
				STEP_B0, STEP_Y: begin
					acc_q <= acc_q + prod_ext;
				end
				STEP_V: begin
					v_q <= to_internal(acc_q);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- src/cascaded_biquad_iir_filter_unit.sv -----
// Top level of the cascaded biquad filter: sequencer, delay memory and datapath.
// Depends on cbq_pkg, cbq_ifs, cbq_ram and cbq_datapath.

// Each input word runs through NUM_SECTIONS direct form II biquad sections
// on one shared multiplier, in eight steps per section, with the section's
// delay pair read from and written back to a single delay memory; the result
// is then loaded into an output register, and the unit returns to idle to
// take the next word. The result sits in the output register, so the next
// word is accepted while it waits; a new result waits until the old one is
// taken. A set restart flag, and the first word after reset, treat all
// delays as zero.

module cascaded_biquad_iir_filter_unit import cbq_pkg::*; #(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int NUM_SECTIONS = DEF_NUM_SECTIONS
) (
	input logic        clk,
	input logic        arst_n,
	cbq_in_if.sink     din,
	cbq_out_if.source  dout
);

	localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
	localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(NUM_SECTIONS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]        state_q;
	logic [SEC_W-1:0]  sec_q;
	logic [STEP_W-1:0] step_q;
	logic              clr_q;
	logic              first_q;
	logic              out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_q;

	logic                           accept;
	logic                           load_out;
	dp_ctl_t                        ctl;
	logic [2*IW-1:0]                rd_data;
	logic [2*IW-1:0]                wr_data;
	logic signed [SAMPLE_WIDTH-1:0] result;

	assign din.ready       = (state_q == ST_IDLE);
	assign accept          = din.valid && din.ready;
	assign load_out        = (state_q == ST_OUT) && (!out_valid_q || dout.ready);
	assign dout.valid      = out_valid_q;
	assign dout.sample_out = out_q;

	assign ctl.load   = accept;
	assign ctl.active = (state_q == ST_RUN);
	assign ctl.step   = step_q;
	assign ctl.row    = ROW_W'(sec_q);
	assign ctl.clr    = clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sec_q       <= '0;
			step_q      <= STEP_G;
			clr_q       <= 1'b0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						clr_q   <= din.restart | first_q;
						first_q <= 1'b0;
						sec_q   <= '0;
						step_q  <= STEP_G;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_V) begin
						if (sec_q == SEC_LAST) begin
							state_q <= ST_OUT;
						end else begin
							sec_q <= sec_q + 1'b1;
						end
					end
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= result;
		end
	end

	cbq_ram #(
		.WIDTH (2 * IW),
		.DEPTH (NUM_SECTIONS),
		.AW    (SEC_W)
	) u_delay_ram (
		.clk   (clk),
		.we    (ctl.active && (step_q == STEP_B0)),
		.waddr (sec_q),
		.wdata (wr_data),
		.re    (ctl.active && (step_q == STEP_G)),
		.raddr (sec_q),
		.rdata (rd_data)
	);

	cbq_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_datapath (
		.clk     (clk),
		.ctl     (ctl),
		.sample  (din.sample_in),
		.rd_data (rd_data),
		.wr_data (wr_data),
		.result  (result)
	);

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && (sec_q == '0) && (step_q == STEP_G))
		else $error("An accepted word did not start at the first section.");

	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q <= SEC_LAST)
		else $error("Section counter out of range.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && out_valid_q && !dout.ready |=> (state_q == ST_OUT))
		else $error("Result overwrote a word that was not taken.");

	a_run_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && (step_q == STEP_V) && (sec_q == SEC_LAST)
		|=> (state_q == ST_OUT))
		else $error("Last section did not hand over to the output stage.");

endmodule

// ----- tb/cascaded_biquad_iir_filter_unit_test.sv -----
`timescale 1ns / 100ps
// Testbench for the cascaded biquad filter unit: a directed table of samples,
// then random segments, every output word checked against a bit-exact predictor,
// or against the table's result for typed rows. Depends on cbq_pkg, cbq_ifs and the filter unit.

module cascaded_biquad_iir_filter_unit_test;
	import cbq_pkg::*;

	localparam int SW           = DEF_SAMPLE_WIDTH;
	localparam int NS           = DEF_NUM_SECTIONS;
	localparam int RANDOM_WORDS = 400;
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 80;
	localparam int DIR_ROWS     = 25;

	localparam longint SEC_G  [NS] = '{9880, 9880, 15860};
	localparam longint SEC_A1 [NS] = '{-17547, 8897, -2916};
	localparam longint SEC_A2 [NS] = '{13812, 13418, 229};
	localparam longint SEC_B0 [NS] = '{16384, 16384, 16384};
	localparam longint SEC_B1 [NS] = '{-11420, 295, -5751};
	localparam longint SEC_B2 [NS] = '{16384, 16384, 16384};

	typedef logic signed [SW-1:0] sample_t;

	typedef struct packed {
		sample_t sample;
		logic    restart;
		logic    typed;
		sample_t result;
	} stim_row_t;

	localparam stim_row_t DIRECTED [DIR_ROWS] = '{
		'{16'sh0000, 1'b0, 1'b1, 16'sh0000},
		'{16'sh0000, 1'b1, 1'b1, 16'sh0000},
		'{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
		'{16'sh0000, 1'b0, 1'b0, 16'sh0000},
		'{16'sh0000, 1'b0, 1'b0, 16'sh0000},
		'{16'sh0000, 1'b0, 1'b0, 16'sh0000},
		'{16'sh0000, 1'b0, 1'b0, 16'sh0000},
		'{16'sh8000, 1'b1, 1'b0, 16'sh0000},
		'{16'sh0000, 1'b0, 1'b0, 16'sh0000},
		'{16'sh0000, 1'b0, 1'b0, 16'sh0000},
		'{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
		'{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
		'{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
		'{16'sh8000, 1'b0, 1'b0, 16'sh0000},
		'{16'sh8000, 1'b0, 1'b0, 16'sh0000},
		'{16'sh8000, 1'b0, 1'b0, 16'sh0000},
		'{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
		'{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
		'{16'sh8000, 1'b0, 1'b0, 16'sh0000},
		'{16'sh8000, 1'b0, 1'b0, 16'sh0000},
		'{16'sh0001, 1'b1, 1'b0, 16'sh0000},
		'{16'shffff, 1'b0, 1'b0, 16'sh0000},
		'{16'sh0000, 1'b1, 1'b1, 16'sh0000},
		'{16'sh5555, 1'b0, 1'b0, 16'sh0000},
		'{16'shaaaa, 1'b0, 1'b0, 16'sh0000}
	};

	logic    clk;
	logic    arst_n;
	int      error_count;
	int      words_out;
	bit      sender_steady;
	bit      held_off;
	sample_t filtered_q [$];
	int_t    sec_d1 [NS];
	int_t    sec_d2 [NS];

	cbq_in_if  #(.SAMPLE_WIDTH(SW)) din_if ();
	cbq_out_if #(.SAMPLE_WIDTH(SW)) dout_if ();

	cascaded_biquad_iir_filter_unit #(
		.SAMPLE_WIDTH(SW),
		.NUM_SECTIONS(NS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	function automatic longint round_q420(longint acc);
		longint r;
		r = (acc + (64'sd1 <<< (FRAC_COEF - 1))) >>> FRAC_COEF;
		if (r > INT_MAX24) begin
			r = INT_MAX24;
		end else if (r < INT_MIN24) begin
			r = INT_MIN24;
		end
		return r;
	endfunction

	function automatic sample_t predict_filtered(sample_t x, logic restart);
		longint v;
		longint d1;
		longint d2;
		longint g;
		longint w;
		longint smax;
		int     s;
		smax = (64'sd1 <<< (SW - 1)) - 1;
		if (restart) begin
			for (s = 0; s < NS; s++) begin
				sec_d1[s] = '0;
				sec_d2[s] = '0;
			end
		end
		v = longint'(x) * (64'sd1 <<< (FRAC_INT + 1 - SW));
		for (s = 0; s < NS; s++) begin
			d1 = sec_d1[s];
			d2 = sec_d2[s];
			g  = round_q420(SEC_G[s] * v);
			w  = round_q420(g * (64'sd1 <<< FRAC_COEF) - SEC_A1[s] * d1 - SEC_A2[s] * d2);
			v  = round_q420(SEC_B0[s] * w + SEC_B1[s] * d1 + SEC_B2[s] * d2);
			sec_d2[s] = int_t'(d1);
			sec_d1[s] = int_t'(w);
		end
		v = (v + (64'sd1 <<< (FRAC_INT - SW))) >>> (FRAC_INT + 1 - SW);
		if (v > smax) begin
			v = smax;
		end else if (v < -smax - 1) begin
			v = -smax - 1;
		end
		return sample_t'(v);
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 3);
		end else if (r < 95) begin
			return $urandom_range(4, 15);
		end
		return $urandom_range(40, 120);
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(sample_t s, logic rst, logic typed, sample_t result);
		int      gap;
		sample_t pred;
		gap = 0;
		if (!sender_steady && $urandom_range(0, 99) >= 60) begin
			gap = gap_len();
		end
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		din_if.valid     <= 1'b1;
		din_if.sample_in <= s;
		din_if.restart   <= rst;
		@(posedge clk);
		while (!din_if.ready) begin
			@(posedge clk);
		end
		pred = predict_filtered(s, rst);
		filtered_q.push_back(typed ? result : pred);
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin : receiver
		int hold;
		int mode_left;
		bit steady;
		hold          = 0;
		mode_left     = 0;
		steady        = 1'b0;
		held_off      = 1'b0;
		dout_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				steady    = ($urandom_range(0, 3) == 0);
				mode_left = $urandom_range(64, 256);
			end
			mode_left--;
			if (hold > 0) begin
				hold--;
				dout_if.ready <= 1'b0;
			end else if (!held_off && words_out >= 60) begin
				held_off      = 1'b1;
				hold          = HOLD_CYCLES - 1;
				dout_if.ready <= 1'b0;
			end else if (steady || $urandom_range(0, 99) < 75) begin
				dout_if.ready <= 1'b1;
			end else begin
				hold          = gap_len() - 1;
				dout_if.ready <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_output
		sample_t want;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			if (filtered_q.size() == 0) begin
				$error("sample_out: expected no word, actual %0d", dout_if.sample_out);
				error_count++;
			end else begin
				want = filtered_q.pop_front();
				if (dout_if.sample_out !== want) begin
					$error("sample_out: expected %0d, actual %0d", want, dout_if.sample_out);
					error_count++;
				end
			end
			words_out++;
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		int      kind;
		int      len;
		int      half;
		int      amp;
		int      count;
		int      i;
		sample_t level;
		sample_t s;
		logic    rst;
		error_count      = 0;
		words_out        = 0;
		sender_steady    = 1'b0;
		arst_n           = 1'b0;
		din_if.valid     = 1'b0;
		din_if.sample_in = '0;
		din_if.restart   = 1'b0;
		for (i = 0; i < NS; i++) begin
			sec_d1[i] = '0;
			sec_d2[i] = '0;
		end
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < DIR_ROWS; i++) begin
			send_word(DIRECTED[i].sample, DIRECTED[i].restart, DIRECTED[i].typed,
				DIRECTED[i].result);
		end

		count = 0;
		while (count < RANDOM_WORDS) begin
			kind          = $urandom_range(0, 99);
			len           = $urandom_range(8, 40);
			half          = $urandom_range(1, 8);
			amp           = $urandom_range(0, 1) ? 32767 : $urandom_range(1000, 32767);
			level         = sample_t'($urandom);
			sender_steady = ($urandom_range(0, 3) == 0);
			for (i = 0; i < len; i++) begin
				rst = (i == 0) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 49) == 0);
				if (kind < 40) begin
					s = ((i / half) % 2) ? sample_t'(-amp - 1) : sample_t'(amp);
				end else if (kind < 65) begin
					s = sample_t'($urandom);
				end else if (kind < 80) begin
					s = level;
				end else if (kind < 90) begin
					s = sample_t'(int'($urandom_range(0, 63)) - 32);
				end else begin
					s   = sample_t'($urandom);
					rst = ($urandom_range(0, 1) == 1);
				end
				send_word(s, rst, 1'b0, '0);
			end
			count += len;
		end
		din_if.valid <= 1'b0;

		while (filtered_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
